@@ rtl/dhd_pkg.sv @@
// shared types and codes for the double hires dot generator
// column records, result items, configuration and mode codes; no dependencies
`default_nettype none

package dhd_pkg;

	localparam int DATA_W  = 30;
	localparam int ACC_W   = 21;
	localparam int COUNT_W = 4;

	// video_mode register codes
	localparam logic [2:0] MODE_MONO560  = 3'd0;
	localparam logic [2:0] MODE_COLOR160 = 3'd1;
	localparam logic [2:0] MODE_MIXED    = 3'd2;
	localparam logic [2:0] MODE_COLOR140 = 3'd3;
	localparam logic [2:0] MODE_FGBG     = 3'd4;

	// register indexes
	localparam logic REG_VIDEO_MODE    = 1'b0;
	localparam logic REG_MONO_OVERRIDE = 1'b1;

	// palette select codes
	localparam logic [1:0] PAL_STD   = 2'd0;
	localparam logic [1:0] PAL_SHIFT = 2'd1;
	localparam logic [1:0] PAL_MONO  = 2'd2;

	// dot widths
	localparam logic [2:0] WIDTH_1 = 3'd1;
	localparam logic [2:0] WIDTH_2 = 3'd2;
	localparam logic [2:0] WIDTH_4 = 3'd4;

	localparam logic [3:0] DOT_ON  = 4'hf;
	localparam logic [3:0] DOT_OFF = 4'h0;

	typedef enum logic [2:0] {
		KIND_MONO,
		KIND_C160,
		KIND_MIXED,
		KIND_C140,
		KIND_FGBG
	} kind_t;

	typedef struct packed {
		logic [7:0] aux_byte;
		logic [7:0] main_byte;
		logic       line_start;
	} in_item_t;

	typedef struct packed {
		logic [3:0] left_index;
		logic [3:0] right_index;
		logic [1:0] palette_select;
		logic [2:0] dot_width;
		logic       last_result;
	} out_item_t;

	typedef struct packed {
		logic [2:0] video_mode;
		logic       mono_override;
	} cfg_t;

	// one column's work, ready for the emitter
	typedef struct packed {
		kind_t              kind;
		logic [1:0]         pal;
		logic [COUNT_W-1:0] count;
		logic [3:0]         modes;
		logic [DATA_W-1:0]  data;
	} job_t;

	typedef struct packed {
		logic ready;
		logic busy;
	} emit_status_t;

endpackage

`default_nettype wire

@@ rtl/double_hires_dot_generator_unit.sv @@
// double hires dot generator: one column in, up to fourteen dot pairs out
// the column's job is registered in the emitter when accepted; each result then passes through the output register
// throughput: one result per cycle unless out_stall holds the output; a column yields 7, 2, 14, 1-2 or 7
// results by mode (mono, color160, mixed, color140, fg/bg), none for a pair's first column in mixed
// or fg/bg; the next column is taken as its predecessor's last result moves into the output register
// reset: video_mode 3, mono_override 0, pairing and color carry cleared, no result pending
// depends on dhd_pkg, dhd_column, dhd_emit
`default_nettype none

module double_hires_dot_generator_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire dhd_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output dhd_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [2:0]         cfg_data
);

	dhd_pkg::cfg_t         cfg_q;
	dhd_pkg::job_t         job;
	logic                  job_ok;
	logic                  take;
	dhd_pkg::emit_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.video_mode    <= dhd_pkg::MODE_COLOR140;
			cfg_q.mono_override <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				dhd_pkg::REG_VIDEO_MODE:    cfg_q.video_mode    <= cfg_data;
				dhd_pkg::REG_MONO_OVERRIDE: cfg_q.mono_override <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall = !status.ready;
	assign take     = in_valid && status.ready;

	dhd_column u_column (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (in_item),
		.cfg    (cfg_q),
		.job    (job),
		.job_ok (job_ok)
	);

	dhd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && job_ok),
		.job       (job),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.status    (status)
	);

endmodule

`default_nettype wire

@@ rtl/dhd_column.sv @@
// column front end: pairing, color140 bit carry and job formation
// depends on dhd_pkg
`default_nettype none

module dhd_column (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire dhd_pkg::in_item_t item,
	input  wire dhd_pkg::cfg_t  cfg,
	output dhd_pkg::job_t       job,
	output logic                job_ok
);

	logic [7:0]                 held_aux_q;
	logic [7:0]                 held_main_q;
	logic                       column_odd_q;
	logic [dhd_pkg::ACC_W-1:0]  acc_q;
	logic [2:0]                 cnt_q;

	dhd_pkg::kind_t             kind;
	logic                       odd_eff;
	logic [dhd_pkg::ACC_W-1:0]  acc_eff;
	logic [2:0]                 cnt_eff;
	logic [dhd_pkg::ACC_W-1:0]  acc_sum;
	logic [4:0]                 acc_total;
	logic [1:0]                 acc_n;
	logic [dhd_pkg::ACC_W-1:0]  acc_next;
	logic [6:0]                 aux7;
	logic [6:0]                 main7;

	assign aux7    = item.aux_byte[6:0];
	assign main7   = item.main_byte[6:0];
	assign odd_eff = item.line_start ? 1'b0 : column_odd_q;
	assign acc_eff = item.line_start ? '0 : acc_q;
	assign cnt_eff = item.line_start ? 3'd0 : cnt_q;

	// effective rendering; override forces mono except color160 and fg/bg
	always_comb begin
		if (cfg.mono_override && cfg.video_mode != dhd_pkg::MODE_COLOR160
				&& cfg.video_mode != dhd_pkg::MODE_FGBG) begin
			kind = dhd_pkg::KIND_MONO;
		end else begin
			case (cfg.video_mode)
				dhd_pkg::MODE_MONO560:  kind = dhd_pkg::KIND_MONO;
				dhd_pkg::MODE_COLOR160: kind = dhd_pkg::KIND_C160;
				dhd_pkg::MODE_MIXED:    kind = dhd_pkg::KIND_MIXED;
				dhd_pkg::MODE_FGBG:     kind = dhd_pkg::KIND_FGBG;
				default:                kind = dhd_pkg::KIND_C140;
			endcase
		end
	end

	// color140: append 14 bits, drain whole bytes
	always_comb begin
		acc_sum   = acc_eff
			| ({{(dhd_pkg::ACC_W-7){1'b0}}, aux7} << cnt_eff)
			| ({{(dhd_pkg::ACC_W-7){1'b0}}, main7} << ({1'b0, cnt_eff} + 4'd7));
		acc_total = {2'b00, cnt_eff} + 5'd14;
		acc_n     = acc_total[4:3];
		acc_next  = acc_sum >> {acc_n, 3'b000};
	end

	always_comb begin
		job       = '0;
		job.kind  = kind;
		job.pal   = dhd_pkg::PAL_STD;
		job_ok    = 1'b1;
		case (kind)
			dhd_pkg::KIND_MONO: begin
				job.pal   = cfg.mono_override ? dhd_pkg::PAL_MONO : dhd_pkg::PAL_STD;
				job.count = 4'd7;
				job.data  = {16'b0, main7, aux7};
			end
			dhd_pkg::KIND_C160: begin
				job.count = 4'd2;
				job.data  = {14'b0, item.main_byte, item.aux_byte};
			end
			dhd_pkg::KIND_MIXED: begin
				job_ok    = odd_eff;
				job.pal   = dhd_pkg::PAL_SHIFT;
				job.count = 4'd14;
				job.modes = {item.main_byte[7], item.aux_byte[7],
					held_main_q[7], held_aux_q[7]};
				job.data  = {2'b0, main7, aux7, held_main_q[6:0], held_aux_q[6:0]};
			end
			dhd_pkg::KIND_FGBG: begin
				job_ok    = odd_eff;
				job.count = 4'd7;
				job.data  = {item.aux_byte, held_aux_q, main7, held_main_q[6:0]};
			end
			default: begin
				job.pal   = dhd_pkg::PAL_SHIFT;
				job.count = {2'b00, acc_n};
				job.data  = {14'b0, acc_sum[15:0]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_aux_q   <= '0;
			held_main_q  <= '0;
			column_odd_q <= 1'b0;
			acc_q        <= '0;
			cnt_q        <= 3'd0;
		end else if (take) begin
			column_odd_q <= 1'b0;
			if (kind == dhd_pkg::KIND_MIXED || kind == dhd_pkg::KIND_FGBG) begin
				column_odd_q <= !odd_eff;
				if (!odd_eff) begin
					held_aux_q  <= item.aux_byte;
					held_main_q <= item.main_byte;
				end
			end
			if (kind == dhd_pkg::KIND_C140) begin
				acc_q <= acc_next;
				cnt_q <= acc_total[2:0];
			end else if (item.line_start) begin
				acc_q <= '0;
				cnt_q <= 3'd0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/dhd_emit.sv @@
// dot pair emitter: holds one column job, steps through its results, output register
// depends on dhd_pkg
`default_nettype none

module dhd_emit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire dhd_pkg::job_t    job,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output dhd_pkg::out_item_t    out_item,
	output dhd_pkg::emit_status_t status
);

	dhd_pkg::job_t                job_s1;
	logic                         job_valid_q;
	logic [dhd_pkg::COUNT_W-1:0]  idx_q;
	dhd_pkg::out_item_t           out_q;
	logic                         out_valid_q;

	dhd_pkg::out_item_t           gen;
	logic                         adv;
	logic                         gen_last;
	logic [4:0]                   k0;
	logic [4:0]                   k1;
	logic [15:0]                  lo16;

	function automatic logic [3:0] mixed_dot(input logic [dhd_pkg::DATA_W-1:0] d,
			input logic [3:0] modes, input logic [4:0] k);
		logic [1:0] grp;
		grp = (k < 5'd7) ? 2'd0 : (k < 5'd14) ? 2'd1 : (k < 5'd21) ? 2'd2 : 2'd3;
		if (modes[grp])
			return d[{k[4:2], 2'b00} +: 4];
		return d[k] ? dhd_pkg::DOT_ON : dhd_pkg::DOT_OFF;
	endfunction

	function automatic logic [3:0] fgbg_dot(input logic [dhd_pkg::DATA_W-1:0] d,
			input logic [4:0] m);
		logic [7:0] c;
		c = (m < 5'd7) ? d[21:14] : d[29:22];
		return d[m] ? c[7:4] : c[3:0];
	endfunction

	assign k0       = {idx_q, 1'b0};
	assign k1       = {idx_q, 1'b1};
	assign lo16     = job_s1.data[15:0];
	assign gen_last = idx_q == job_s1.count - 4'd1;
	assign adv      = job_valid_q && (!out_valid_q || !out_stall);

	always_comb begin
		gen                = '0;
		gen.palette_select = job_s1.pal;
		gen.last_result    = gen_last;
		case (job_s1.kind)
			dhd_pkg::KIND_MONO: begin
				gen.left_index  = job_s1.data[k0] ? dhd_pkg::DOT_ON : dhd_pkg::DOT_OFF;
				gen.right_index = job_s1.data[k1] ? dhd_pkg::DOT_ON : dhd_pkg::DOT_OFF;
				gen.dot_width   = dhd_pkg::WIDTH_1;
			end
			dhd_pkg::KIND_MIXED: begin
				gen.left_index  = mixed_dot(job_s1.data, job_s1.modes, k0);
				gen.right_index = mixed_dot(job_s1.data, job_s1.modes, k1);
				gen.dot_width   = dhd_pkg::WIDTH_1;
			end
			dhd_pkg::KIND_FGBG: begin
				gen.left_index  = fgbg_dot(job_s1.data, k0);
				gen.right_index = fgbg_dot(job_s1.data, k1);
				gen.dot_width   = dhd_pkg::WIDTH_2;
			end
			default: begin
				// color160 and color140: one byte per result, low nibble first
				gen.left_index  = lo16[{idx_q[0], 3'b000} +: 4];
				gen.right_index = lo16[{idx_q[0], 3'b100} +: 4];
				gen.dot_width   = dhd_pkg::WIDTH_4;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load)
			job_s1 <= job;
		if (adv)
			out_q <= gen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 4'd1;
				if (gen_last)
					job_valid_q <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
	assign status.ready  = !job_valid_q || (adv && gen_last);
	assign status.busy   = job_valid_q;

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> idx_q < job_s1.count)
		else $error("result index past job count");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> job_s1.count != 4'd0)
		else $error("job held with no results");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!job_valid_q || (adv && gen_last)))
		else $error("job overwritten before its last result");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && gen_last) |=> (out_valid_q && out_q.last_result))
		else $error("last result not marked");
`endif

endmodule

`default_nettype wire
